/* src/bli_pkg.sv */
package bli_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 16;
  localparam int unsigned ModeW  = 2;

  // s_tdata: item_value [31:0], position [47:32]
  localparam int unsigned InDataW = ValueW + PosW;
  // m_tuser: list_empty [0], insert_dropped [1]
  localparam int unsigned OutUserW = 2;

  localparam logic [ModeW-1:0] MODE_INS_FRONT = 2'd0;
  localparam logic [ModeW-1:0] MODE_INS_BACK  = 2'd1;
  localparam logic [ModeW-1:0] MODE_DELETE    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_FINISH,
    ST_EMIT
  } bli_state_t;

endpackage

/* src/bounded_list_insert_delete_unit.sv */
// A back insert, a front insert into an empty list, a delete of the last element, an ignored
// delete or a dropped insert updates the list directly; a front insert into a non-empty list
// and a delete at any other position first shift the entries in ST_SHIFT, then ST_FINISH. The
// list then streams out from the front after a registered read. A new request is taken only
// in ST_IDLE, once the last element is loaded into the output register. Entries are moved by
// the one-read, one-write shift sequencer. Reset: rst (sync, high) empties the list.
module bounded_list_insert_delete_unit #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // slave side
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bli_pkg::InDataW-1:0]   s_tdata,   // item_value [31:0], position [47:32]
  input  logic [bli_pkg::ModeW-1:0]     s_tuser,   // mode [1:0]
  // master side
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bli_pkg::ValueW-1:0]    m_tdata,   // element [31:0]
  output logic [bli_pkg::OutUserW-1:0]  m_tuser,   // list_empty [0], insert_dropped [1]
  output logic                          m_tlast
);
  import bli_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // List memory, front at entry 0. One write port and one registered read port.
  logic [ValueW-1:0] mem [CAPACITY];
  logic [ValueW-1:0] rd_data;

  bli_state_t state, state_next;

  logic [CNT_W-1:0]  count;        // valid entries
  logic [ValueW-1:0] value_reg;    // value held for a front insert
  logic              dropped;      // insert refused on a full list
  logic              shift_up;     // 1: front insert moves up, 0: delete moves down
  logic [IDX_W-1:0]  sh_src;       // next entry to read during a shift
  logic [IDX_W-1:0]  sh_dst;       // where the pending read lands
  logic [CNT_W-1:0]  sh_left;      // moves still to issue
  logic              sh_pend;      // rd_data holds a word to write back
  logic [CNT_W-1:0]  rd_idx;       // next entry to read during emit
  logic              em_pend;      // rd_data holds an element to emit
  logic              em_last;      // that element is the final one

  // Unpacked request fields
  logic [ModeW-1:0]  in_mode;
  logic [ValueW-1:0] in_value;
  logic [PosW-1:0]   in_pos;
  assign in_mode  = s_tuser;
  assign in_value = s_tdata[ValueW-1:0];
  assign in_pos   = s_tdata[InDataW-1:ValueW];

  // Request decode
  logic in_accept, is_insert, is_back, full, pos_in_range, pos_is_tail;
  logic direct_write, need_shift;

  assign in_accept    = s_tvalid && s_tready;
  assign is_insert    = (in_mode == MODE_INS_FRONT) || (in_mode == MODE_INS_BACK);
  assign is_back      = (in_mode == MODE_INS_BACK);
  assign full         = (count == CNT_W'(CAPACITY));
  assign pos_in_range = in_pos < PosW'(count);
  assign pos_is_tail  = (in_pos == PosW'(count) - PosW'(1));
  // A back insert, or a front insert into an empty list, writes straight to entry count.
  assign direct_write = is_insert && !full && (is_back || (count == '0));
  assign need_shift   = is_insert ? (!full && !is_back && (count != '0))
                                  : (pos_in_range && !pos_is_tail);

  // Sequencer controls
  logic              out_free, sh_issue, em_issue, em_load, em_empty_load;
  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [ValueW-1:0] wr_data;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    sh_issue      = 1'b0;
    em_issue      = 1'b0;
    em_load       = 1'b0;
    em_empty_load = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = rd_idx[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = count[IDX_W-1:0];
    wr_data       = in_value;
    unique case (state)
      ST_IDLE: begin
        wr_en = in_accept && direct_write;
      end
      ST_SHIFT: begin
        // Read one entry a cycle, write the previous read back one slot over.
        sh_issue = (sh_left != '0);
        rd_en    = sh_issue;
        rd_addr  = sh_src;
        wr_en    = sh_pend;
        wr_addr  = sh_dst;
        wr_data  = rd_data;
      end
      ST_FINISH: begin
        // Front insert drops its value into the freed front slot.
        wr_en   = shift_up;
        wr_addr = '0;
        wr_data = value_reg;
      end
      ST_EMIT: begin
        em_load       = em_pend && out_free;
        em_issue      = (rd_idx < count) && (!em_pend || em_load);
        em_empty_load = (count == '0) && out_free;
        rd_en         = em_issue;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = need_shift ? ST_SHIFT : ST_EMIT;
        end
      end
      ST_SHIFT: begin
        if ((sh_left == '0) && !sh_pend) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (em_empty_load || (em_load && em_last)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold off transfers while reset is applied
  assign s_tready = (state == ST_IDLE) && !rst;

  // Memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      sh_pend  <= 1'b0;
      em_pend  <= 1'b0;
      rd_idx   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;

      // Element count
      if (state == ST_IDLE && in_accept) begin
        if (direct_write) begin
          count <= count + CNT_W'(1);
        end else if (!is_insert && pos_in_range && pos_is_tail) begin
          count <= count - CNT_W'(1);
        end
      end else if (state == ST_FINISH) begin
        count <= shift_up ? count + CNT_W'(1) : count - CNT_W'(1);
      end

      sh_pend <= sh_issue;

      // Emit read pointer: restart at the front outside emit
      if (state != ST_EMIT) begin
        rd_idx <= '0;
      end else if (em_issue) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end

      if (em_issue) begin
        em_pend <= 1'b1;
      end else if (em_load) begin
        em_pend <= 1'b0;
      end

      // Output register: load, or drop once taken
      if (em_load || em_empty_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_accept) begin
      value_reg <= in_value;
      dropped   <= is_insert && full;
      shift_up  <= is_insert;
      if (is_insert) begin
        sh_src  <= IDX_W'(count - CNT_W'(1));
        sh_left <= count;
      end else begin
        sh_src  <= IDX_W'(in_pos + PosW'(1));
        sh_left <= count - in_pos[CNT_W-1:0] - CNT_W'(1);
      end
    end else if (sh_issue) begin
      sh_dst  <= shift_up ? sh_src + IDX_W'(1) : sh_src - IDX_W'(1);
      sh_src  <= shift_up ? sh_src - IDX_W'(1) : sh_src + IDX_W'(1);
      sh_left <= sh_left - CNT_W'(1);
    end

    if (em_issue) begin
      em_last <= (rd_idx + CNT_W'(1) == count);
    end

    if (em_load) begin
      m_tdata    <= rd_data;
      m_tuser[0] <= 1'b0;
      m_tuser[1] <= dropped;
      m_tlast    <= em_last;
    end else if (em_empty_load) begin
      m_tdata    <= '0;
      m_tuser[0] <= 1'b1;
      m_tuser[1] <= dropped;
      m_tlast    <= 1'b1;
    end
  end

endmodule

/* src/bli_checker.sv */
module bli_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [bli_pkg::ValueW-1:0]    m_tdata,
  input logic [bli_pkg::OutUserW-1:0]  m_tuser,
  input logic                          m_tlast
);

  // An empty-list result is always the only, and so final, result.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tlast)
    else $error("empty-list result without tlast");

  // No new request while a listing is still in progress.
  a_busy_mid_list: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> !s_tready)
    else $error("request accepted in the middle of a listing");

  // Every request takes at least the emit step before the next one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready again right after a transfer");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind bounded_list_insert_delete_unit bli_checker u_bli_checker (.*);
